>>> hw/rtl/ugc_pkg.sv
package ugc_pkg;

    localparam int CP_BITS        = 21;
    localparam int COUNT_BITS_DEF = 16;
    localparam int OUT_COUNT_W    = 16;

    localparam logic [CP_BITS-1:0] CP_JOINER   = 21'h0200D;
    localparam logic [CP_BITS-1:0] CP_IND_LO   = 21'h1F1E6;
    localparam logic [CP_BITS-1:0] CP_IND_HI   = 21'h1F1FF;
    localparam logic [CP_BITS-1:0] CP_MARK0_LO = 21'h00300;
    localparam logic [CP_BITS-1:0] CP_MARK0_HI = 21'h0036F;
    localparam logic [CP_BITS-1:0] CP_MARK1_LO = 21'h01AB0;
    localparam logic [CP_BITS-1:0] CP_MARK1_HI = 21'h01AFF;
    localparam logic [CP_BITS-1:0] CP_MARK2_LO = 21'h01DC0;
    localparam logic [CP_BITS-1:0] CP_MARK2_HI = 21'h01DFF;
    localparam logic [CP_BITS-1:0] CP_MARK3_LO = 21'h020D0;
    localparam logic [CP_BITS-1:0] CP_MARK3_HI = 21'h020FF;
    localparam logic [CP_BITS-1:0] CP_MARK4_LO = 21'h0FE20;
    localparam logic [CP_BITS-1:0] CP_MARK4_HI = 21'h0FE2F;
    localparam logic [CP_BITS-1:0] CP_VSEL_LO  = 21'h0FE00;
    localparam logic [CP_BITS-1:0] CP_VSEL_HI  = 21'h0FE0F;
    localparam logic [CP_BITS-1:0] CP_VSUP_LO  = 21'hE0100;
    localparam logic [CP_BITS-1:0] CP_VSUP_HI  = 21'hE01EF;

    // codepoint class; all clear means an ordinary nonzero codepoint (ASCII, U+FFFD)
    typedef struct packed {
        logic zero;
        logic mark;
        logic ind;
        logic zwj;
    } t_cls;

    localparam t_cls CLS_PLAIN = '0;

    // one accepted byte after decode
    typedef struct packed {
        logic a_vld;   // codepoint from the pending sequence (completed or broken)
        t_cls a_cls;
        logic b_vld;   // byte read as a lead gives a plain codepoint
        logic b_end;   // raw zero lead byte
        logic c_vld;   // sequence cut off by the end of the beat marked last
        logic last;
    } t_evt;

    typedef struct packed {
        logic opened;
        logic absorb;
        logic base;
        logic ended;
    } t_clu;

    typedef struct packed {
        t_clu st;
        logic started;
    } t_take;

    function automatic logic in_rng(logic [CP_BITS-1:0] cp, logic [CP_BITS-1:0] lo,
                                    logic [CP_BITS-1:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic t_cls classify(logic [CP_BITS-1:0] cp);
        t_cls c;
        c.zero = (cp == '0);
        c.ind  = in_rng(cp, CP_IND_LO, CP_IND_HI);
        c.zwj  = (cp == CP_JOINER);
        c.mark = in_rng(cp, CP_MARK0_LO, CP_MARK0_HI) || in_rng(cp, CP_MARK1_LO, CP_MARK1_HI) ||
                 in_rng(cp, CP_MARK2_LO, CP_MARK2_HI) || in_rng(cp, CP_MARK3_LO, CP_MARK3_HI) ||
                 in_rng(cp, CP_MARK4_LO, CP_MARK4_HI) || in_rng(cp, CP_VSEL_LO, CP_VSEL_HI) ||
                 in_rng(cp, CP_VSUP_LO, CP_VSUP_HI);
        return c;
    endfunction

    function automatic t_take take_cp(t_clu s, t_cls c);
        t_take r;
        r.st      = s;
        r.started = 1'b0;
        if (!s.ended) begin
            priority if (c.zero && !s.absorb) begin
                r.st.ended = 1'b1;
            end else if (!s.opened) begin
                r.st.opened = 1'b1;
                r.st.base   = c.ind;
                r.st.absorb = 1'b0;
                r.started   = 1'b1;
            end else if (s.absorb) begin
                r.st.absorb = 1'b0;
            end else if (c.zwj) begin
                r.st.absorb = 1'b1;
            end else if (!c.mark) begin
                if (s.base && c.ind) begin
                    r.st.base = 1'b0;
                end else begin
                    r.st.base   = c.ind;
                    r.st.absorb = 1'b0;
                    r.started   = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/ugc_front.sv
module ugc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_evt_vld,
    input  logic          i_evt_rdy,
    output ugc_pkg::t_evt o_evt
);
    import ugc_pkg::*;

    logic [1:0]         r_pend, n_pend;
    logic [CP_BITS-1:0] r_part, n_part;
    logic [CP_BITS-1:0] cp_acc;
    logic               lead;
    t_evt               evt;

    assign cp_acc = {r_part[CP_BITS-7:0], i_byte[5:0]};

    always_comb begin
        evt    = '0;
        n_pend = r_pend;
        n_part = r_part;
        lead   = 1'b1;
        if (r_pend != 2'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                n_part = cp_acc;
                n_pend = r_pend - 2'd1;
                lead   = 1'b0;
                if (r_pend == 2'd1) begin
                    evt.a_vld = 1'b1;
                    evt.a_cls = classify(cp_acc);
                end
            end else begin
                evt.a_vld = 1'b1;
                evt.a_cls = CLS_PLAIN;
                n_pend    = 2'd0;
            end
        end
        if (lead) begin
            priority if (i_byte == 8'h00) begin
                evt.b_end = 1'b1;
            end else if (i_byte[7] == 1'b0 || i_byte[7:6] == 2'b10) begin
                evt.b_vld = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                n_part = CP_BITS'(i_byte[4:0]);
                n_pend = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_part = CP_BITS'(i_byte[3:0]);
                n_pend = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_part = CP_BITS'(i_byte[2:0]);
                n_pend = 2'd3;
            end else begin
                evt.b_vld = 1'b1;
            end
        end
        evt.last = i_last;
        if (i_last) begin
            evt.c_vld = (n_pend != 2'd0);
            n_pend    = 2'd0;
            n_part    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_part <= '0;
        end else if (i_valid && i_evt_rdy) begin
            r_pend <= n_pend;
            r_part <= n_part;
        end
    end

    assign o_ready   = i_evt_rdy;
    assign o_evt_vld = i_valid;
    assign o_evt     = evt;

endmodule

>>> hw/rtl/ugc_queue.sv
module ugc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_vld,
    output logic          o_wr_rdy,
    input  ugc_pkg::t_evt i_wr_evt,
    output logic          o_rd_vld,
    input  logic          i_rd_rdy,
    output ugc_pkg::t_evt o_rd_evt
);
    import ugc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_evt             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             wr, rd;

    assign o_wr_rdy = (r_cnt != CNT_W'(DEPTH));
    assign o_rd_vld = (r_cnt != '0);
    assign wr       = i_wr_vld && o_wr_rdy;
    assign rd       = o_rd_vld && i_rd_rdy;
    assign o_rd_evt = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/ugc_back.sv
module ugc_back #(
    parameter int COUNT_BITS = ugc_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_evt_vld,
    output logic                            o_evt_rdy,
    input  ugc_pkg::t_evt                   i_evt,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_started,
    output logic [ugc_pkg::OUT_COUNT_W-1:0] o_count,
    output logic                            o_done
);
    import ugc_pkg::*;

    localparam int WIDE_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

    t_clu                  r_clu, n_clu;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic                  r_out_vld;
    logic [1:0]            r_started;
    logic [OUT_COUNT_W-1:0] r_count;
    logic                  r_done;

    t_take                 ta, tb, tc;
    t_clu                  s1, s2, s3;
    logic [1:0]            started;
    logic [COUNT_BITS:0]   sum;
    logic [WIDE_W-1:0]     total_wide;
    logic                  pop;

    assign pop       = i_evt_vld && (!r_out_vld || i_ready);
    assign o_evt_rdy = !r_out_vld || i_ready;

    always_comb begin
        ta = take_cp(r_clu, i_evt.a_cls);
        s1 = i_evt.a_vld ? ta.st : r_clu;
        tb = take_cp(s1, CLS_PLAIN);
        s2 = s1;
        if (i_evt.b_end) begin
            s2.ended = 1'b1;
        end else if (i_evt.b_vld) begin
            s2 = tb.st;
        end
        tc = take_cp(s2, CLS_PLAIN);
        s3 = i_evt.c_vld ? tc.st : s2;
        started = 2'({1'b0, i_evt.a_vld && ta.started})
                + 2'({1'b0, i_evt.b_vld && !i_evt.b_end && tb.started})
                + 2'({1'b0, i_evt.c_vld && tc.started});
        sum     = {1'b0, r_total} + (COUNT_BITS + 1)'(started);
        n_total = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        n_clu   = s3;
        total_wide = WIDE_W'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clu     <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (pop) begin
                r_clu   <= i_evt.last ? '0 : n_clu;
                r_total <= i_evt.last ? '0 : n_total;
            end
            if (pop) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_started <= started;
            r_count   <= total_wide[OUT_COUNT_W-1:0];
            r_done    <= n_clu.ended || i_evt.last;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_started = r_started;
    assign o_count   = r_count;
    assign o_done    = r_done;

endmodule

>>> hw/rtl/utf8_grapheme_cluster_counter.sv
// UTF-8 grapheme cluster counter.
// Input channel (i_in_valid / o_in_ready): one byte of a UTF-8 string per beat,
// with i_last_byte marking the final byte of the string. A zero byte also ends it.
// Output channel (o_out_valid / i_out_ready): exactly one result beat per input
// beat, in order: clusters started by that byte, the running cluster count
// (saturating at 2^COUNT_BITS-1) and a done flag once the string has ended.
// Decode and classify write each accepted byte's event into a 2-entry queue;
// the cluster-state update then writes the result into the output register as
// the event leaves the queue. Throughput: one byte per cycle while the receiver
// takes every result, set by the cluster state update in the back end; decode
// state and cluster state are each one register set, so consecutive bytes follow
// with no gap.
// When the receiver stalls, the output register holds its beat, the queue fills,
// and o_in_ready drops once both queue entries are taken.
// Reset (synchronous, active low) clears decode state, cluster state, count and
// queue; no result is pending afterwards. The same clearing happens to the string
// state after each beat marked last.
module utf8_grapheme_cluster_counter #(
    parameter int COUNT_BITS = ugc_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_clusters_started,
    output logic [ugc_pkg::OUT_COUNT_W-1:0] o_cluster_count,
    output logic                            o_string_done
);
    import ugc_pkg::*;

    logic f_vld, f_rdy, q_vld, q_rdy;
    t_evt f_evt, q_evt;

    ugc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_byte    (i_text_byte),
        .i_last    (i_last_byte),
        .o_evt_vld (f_vld),
        .i_evt_rdy (f_rdy),
        .o_evt     (f_evt)
    );

    ugc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_vld (f_vld),
        .o_wr_rdy (f_rdy),
        .i_wr_evt (f_evt),
        .o_rd_vld (q_vld),
        .i_rd_rdy (q_rdy),
        .o_rd_evt (q_evt)
    );

    ugc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt_vld (q_vld),
        .o_evt_rdy (q_rdy),
        .i_evt     (q_evt),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_started (o_clusters_started),
        .o_count   (o_cluster_count),
        .o_done    (o_string_done)
    );

endmodule
